FILE: rtl/core/mlbpc_pkg.sv
// Shared types and constants for the multi-LED blink pattern controller.
// Used by mlbpc_ctrl, mlbpc_datapath, the top level and the checker.
package mlbpc_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int IDX_W         = 3;
    localparam int OUT_W         = 8;
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_SLOTS     = 8;   // led_index reaches LEDs 0 to 7 only

    localparam logic [CFG_W-1:0] SLOW_HALF_RST  = 8'd100;
    localparam logic [CFG_W-1:0] QUICK_HALF_RST = 8'd10;
    localparam logic [CFG_W-1:0] PULSE_HALF_RST = 8'd20;
    localparam logic [CFG_W-1:0] PULSE_DARK_RST = 8'd80;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_OFF    = 3'd1,
        CMD_ON     = 3'd2,
        CMD_SLOW   = 3'd3,
        CMD_QUICK  = 3'd4,
        CMD_SINGLE = 3'd5,
        CMD_DOUBLE = 3'd6
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOW_HALF  = 2'd0,
        CFG_QUICK_HALF = 2'd1,
        CFG_PULSE_HALF = 2'd2,
        CFG_PULSE_DARK = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic set_en;      // store mode for led_index, clear its counters
        logic clear_mask;  // start of a tick: clear the driven mask
        logic step_en;     // step the LED selected by the slot counter
        logic load_out;    // copy levels and mask into the output register
    } ctrl_cmd_t;

endpackage

FILE: rtl/core/mlbpc_ctrl.sv
// Controller state machine: accepts requests, walks the LED slots on a tick
// and hands results to the output. Depends on mlbpc_pkg.
module mlbpc_ctrl #(
    parameter int LED_COUNT = mlbpc_pkg::LED_COUNT_DEF,
    localparam int NUM_SLOTS = (LED_COUNT < mlbpc_pkg::MAX_SLOTS) ?
                               LED_COUNT : mlbpc_pkg::MAX_SLOTS,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic [mlbpc_pkg::IDX_W-1:0] led_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output mlbpc_pkg::ctrl_cmd_t        cmd,
    output logic [SLOT_W-1:0]           slot
);

    mlbpc_pkg::state_t   state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;
    logic                index_ok;

    assign accept   = in_valid && !in_stall;
    assign index_ok = ({1'b0, led_index} < (mlbpc_pkg::IDX_W + 1)'(NUM_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlbpc_pkg::ST_IDLE;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        in_stall       = 1'b1;

        unique case (state_reg)
            mlbpc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    if (command == mlbpc_pkg::CMD_TICK)
                    begin
                        cmd.clear_mask = 1'b1;
                        slot_next      = '0;
                        state_next     = mlbpc_pkg::ST_STEP;
                    end
                    else if (command <= mlbpc_pkg::CMD_DOUBLE && index_ok)
                    begin
                        cmd.set_en = 1'b1;
                    end
                end
            end
            mlbpc_pkg::ST_STEP:
            begin
                cmd.step_en = 1'b1;
                if (slot_reg == SLOT_W'(NUM_SLOTS - 1))
                    state_next = mlbpc_pkg::ST_DONE;
                else
                    slot_next = slot_reg + 1'b1;
            end
            mlbpc_pkg::ST_DONE:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mlbpc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlbpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;

endmodule

FILE: rtl/core/mlbpc_datapath.sv
// Datapath: configuration registers, per-LED pattern state, the shared
// one-LED step unit and the output register. Depends on mlbpc_pkg.
module mlbpc_datapath #(
    parameter int LED_COUNT = mlbpc_pkg::LED_COUNT_DEF,
    localparam int NUM_SLOTS = (LED_COUNT < mlbpc_pkg::MAX_SLOTS) ?
                               LED_COUNT : mlbpc_pkg::MAX_SLOTS,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [2:0]                      command,
    input  logic [mlbpc_pkg::IDX_W-1:0]     led_index,
    input  logic                            cfg_write_en,
    input  logic [mlbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlbpc_pkg::CFG_W-1:0]     cfg_data,
    input  mlbpc_pkg::ctrl_cmd_t            cmd,
    input  logic [SLOT_W-1:0]               slot,
    output logic [mlbpc_pkg::OUT_W-1:0]     led_levels,
    output logic [mlbpc_pkg::OUT_W-1:0]     led_driven
);

    logic [7:0] slow_half_reg, quick_half_reg, pulse_half_reg, pulse_dark_reg;

    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] level_reg;
    logic [NUM_SLOTS-1:0] driven_reg;
    logic [2:0]           mode_reg   [NUM_SLOTS];
    logic [7:0]           phase_reg  [NUM_SLOTS];
    logic [1:0]           half_reg   [NUM_SLOTS];
    logic [7:0]           dark_reg   [NUM_SLOTS];
    logic                 toggle_reg [NUM_SLOTS];

    logic [mlbpc_pkg::OUT_W-1:0] levels_out_reg, driven_out_reg;

    logic [SLOT_W-1:0] set_slot;
    logic [2:0]        mode_cur;
    logic [7:0]        phase_cur, dark_cur, len;
    logic [1:0]        half_cur, pulses;
    logic              toggle_cur;
    logic [7:0]        phase_next, dark_next;
    logic [1:0]        half_next;
    logic              toggle_next;
    logic              drive, level, run_half, pulse_mode, do_step;

    assign set_slot = led_index[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_half_reg  <= mlbpc_pkg::SLOW_HALF_RST;
            quick_half_reg <= mlbpc_pkg::QUICK_HALF_RST;
            pulse_half_reg <= mlbpc_pkg::PULSE_HALF_RST;
            pulse_dark_reg <= mlbpc_pkg::PULSE_DARK_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                mlbpc_pkg::CFG_SLOW_HALF:  slow_half_reg  <= cfg_data;
                mlbpc_pkg::CFG_QUICK_HALF: quick_half_reg <= cfg_data;
                mlbpc_pkg::CFG_PULSE_HALF: pulse_half_reg <= cfg_data;
                mlbpc_pkg::CFG_PULSE_DARK: pulse_dark_reg <= cfg_data;
                default:                   slow_half_reg  <= slow_half_reg;
            endcase
        end
    end

    assign mode_cur   = mode_reg[slot];
    assign phase_cur  = phase_reg[slot];
    assign half_cur   = half_reg[slot];
    assign dark_cur   = dark_reg[slot];
    assign toggle_cur = toggle_reg[slot];
    assign do_step    = cmd.step_en && active_reg[slot];

    // One pattern step for the selected LED
    always_comb
    begin
        phase_next  = phase_cur;
        half_next   = half_cur;
        dark_next   = dark_cur;
        toggle_next = toggle_cur;
        drive       = 1'b0;
        level       = 1'b0;
        run_half    = 1'b0;
        pulse_mode  = 1'b0;
        len         = pulse_half_reg;
        pulses      = 2'd1;

        case (mode_cur) inside
            mlbpc_pkg::CMD_ON:
            begin
                drive = 1'b1;
                level = 1'b1;
            end
            mlbpc_pkg::CMD_SLOW:
            begin
                run_half = 1'b1;
                len      = slow_half_reg;
            end
            mlbpc_pkg::CMD_QUICK:
            begin
                run_half = 1'b1;
                len      = quick_half_reg;
            end
            mlbpc_pkg::CMD_SINGLE, mlbpc_pkg::CMD_DOUBLE:
            begin
                pulse_mode = 1'b1;
                if (mode_cur == mlbpc_pkg::CMD_DOUBLE)
                    pulses = 2'd2;
                if (half_cur <= pulses)
                begin
                    run_half = 1'b1;
                end
                else if (pulse_dark_reg > dark_cur)
                begin
                    dark_next = dark_cur + 8'd1;
                    drive     = 1'b1;
                end
                else
                begin
                    // gap over: restart the burst
                    toggle_next = 1'b0;
                    dark_next   = '0;
                    half_next   = '0;
                end
            end
            default:
            begin
                drive = 1'b1;
            end
        endcase

        if (run_half)
        begin
            if (phase_cur == '0)
            begin
                toggle_next = ~toggle_cur;
                drive       = 1'b1;
                level       = ~toggle_cur;
            end
            if (phase_cur >= len)
            begin
                phase_next = '0;
                if (pulse_mode)
                    half_next = half_cur + 2'd1;
            end
            else
            begin
                phase_next = phase_cur + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            level_reg  <= '0;
            driven_reg <= '0;
        end
        else
        begin
            if (cmd.set_en)
                active_reg[set_slot] <= 1'b1;
            if (cmd.clear_mask)
                driven_reg <= '0;
            if (do_step && drive)
            begin
                driven_reg[slot] <= 1'b1;
                level_reg[slot]  <= level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_en)
        begin
            mode_reg[set_slot]   <= command;
            phase_reg[set_slot]  <= '0;
            half_reg[set_slot]   <= '0;
            dark_reg[set_slot]   <= '0;
            toggle_reg[set_slot] <= 1'b0;
        end
        else if (do_step)
        begin
            phase_reg[slot]  <= phase_next;
            half_reg[slot]   <= half_next;
            dark_reg[slot]   <= dark_next;
            toggle_reg[slot] <= toggle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            levels_out_reg <= mlbpc_pkg::OUT_W'(level_reg);
            driven_out_reg <= mlbpc_pkg::OUT_W'(driven_reg);
        end
    end

    assign led_levels = levels_out_reg;
    assign led_driven = driven_out_reg;

endmodule

FILE: rtl/core/multi_led_blink_pattern_controller.sv
// A set request is done without leaving idle. A tick request steps one LED per cycle
// through the min(LED_COUNT, 8) slots in the shared step unit, then loads the output
// register once any earlier result has been taken; no new request is taken
// until the tick's result is loaded.
// Reset marks every LED inactive and unlit and drops any waiting result; config
// registers take defaults. Depends on mlbpc_pkg, mlbpc_ctrl and mlbpc_datapath.
module multi_led_blink_pattern_controller #(
    parameter int LED_COUNT = mlbpc_pkg::LED_COUNT_DEF,
    localparam int NUM_SLOTS = (LED_COUNT < mlbpc_pkg::MAX_SLOTS) ?
                               LED_COUNT : mlbpc_pkg::MAX_SLOTS,
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      command,
    input  logic [mlbpc_pkg::IDX_W-1:0]     led_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mlbpc_pkg::OUT_W-1:0]     led_levels,
    output logic [mlbpc_pkg::OUT_W-1:0]     led_driven,
    input  logic                            cfg_write_en,
    input  logic [mlbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlbpc_pkg::CFG_W-1:0]     cfg_data
);

    mlbpc_pkg::ctrl_cmd_t cmd;
    logic [SLOT_W-1:0]    slot;

    mlbpc_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .led_index (led_index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .slot      (slot)
    );

    mlbpc_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .led_index    (led_index),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .slot         (slot),
        .led_levels   (led_levels),
        .led_driven   (led_driven)
    );

endmodule

FILE: rtl/core/mlbpc_checker.sv
// Port-level checks for the multi-LED blink pattern controller, bound to
// the top level. Depends on mlbpc_pkg.
module mlbpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [2:0]                      command,
    input logic [mlbpc_pkg::IDX_W-1:0]     led_index,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [mlbpc_pkg::OUT_W-1:0]     led_levels,
    input logic [mlbpc_pkg::OUT_W-1:0]     led_driven,
    input logic                            cfg_write_en,
    input logic [mlbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [mlbpc_pkg::CFG_W-1:0]     cfg_data
);

    logic tick_accept;

    assign tick_accept = in_valid && !in_stall && command == mlbpc_pkg::CMD_TICK;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_levels) && $stable(led_driven))
        else $error("result changed while stalled");

    // a tick keeps the block busy while the LEDs are stepped
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> in_stall ##1 in_stall)
        else $error("tick request did not occupy the step sequence");

    // no result appears the cycle right after a tick request
    a_tick_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> !$rose(out_valid))
        else $error("result raised too early after a tick");

    // a new result comes only at the end of busy stepping
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without a tick in progress");

    // cfg writes with index != data[1:0] keep a waiting result's levels
    a_cfg_no_touch: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en && out_valid && out_stall && cfg_index != cfg_data[1:0]
        |=> $stable(led_levels))
        else $error("configuration write changed a pending result");

endmodule

bind multi_led_blink_pattern_controller mlbpc_checker u_mlbpc_checker (.*);

FILE: bench/mlbpc_checker.sv
// Checker for the multi-LED blink pattern controller: watches requests, register
// writes and results, predicts each tick's levels and driven mask, compares.
// Depends on mlbpc_pkg.
module mlbpc_tb_checker #(
    parameter int LED_COUNT = mlbpc_pkg::LED_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [2:0]                      command,
    input  logic [mlbpc_pkg::IDX_W-1:0]     led_index,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [mlbpc_pkg::OUT_W-1:0]     led_levels,
    input  logic [mlbpc_pkg::OUT_W-1:0]     led_driven,
    input  logic                            cfg_write_en,
    input  logic [mlbpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mlbpc_pkg::CFG_W-1:0]     cfg_data,
    output int                              errors,
    output int                              pending
);

    localparam logic [1:0] SINGLE_LAST_HALF = 2'd1;
    localparam logic [1:0] DOUBLE_LAST_HALF = 2'd2;

    typedef struct packed {
        logic [mlbpc_pkg::OUT_W-1:0] levels;
        logic [mlbpc_pkg::OUT_W-1:0] driven;
    } tick_result_t;

    tick_result_t tick_results_q[$];

    logic [mlbpc_pkg::CFG_W-1:0]     slow_len, quick_len, pulse_len, dark_len;
    logic [mlbpc_pkg::MAX_SLOTS-1:0] led_active, toggle_bits, lit, driven_now;
    logic [2:0]                      led_mode  [mlbpc_pkg::MAX_SLOTS];
    logic [7:0]                      phase     [mlbpc_pkg::MAX_SLOTS];
    logic [1:0]                      halves    [mlbpc_pkg::MAX_SLOTS];
    logic [7:0]                      dark_ticks[mlbpc_pkg::MAX_SLOTS];
    int                              fail_count;

    function automatic void drive_led(int i, logic lvl);
        driven_now[i] = 1'b1;
        lit[i] = lvl;
    endfunction

    // One tick of a half period; returns 1 when the half period ends.
    function automatic logic step_half_period(int i, logic [mlbpc_pkg::CFG_W-1:0] len);
        if (phase[i] == 8'd0)
        begin
            toggle_bits[i] = ~toggle_bits[i];
            drive_led(i, toggle_bits[i]);
        end
        if (phase[i] >= len)
        begin
            phase[i] = 8'd0;
            return 1'b1;
        end
        phase[i] = phase[i] + 8'd1;
        return 1'b0;
    endfunction

    function automatic void step_burst(int i, logic [1:0] last_half);
        if (halves[i] <= last_half)
        begin
            if (step_half_period(i, pulse_len))
                halves[i] = halves[i] + 2'd1;
        end
        else if (dark_len > dark_ticks[i])
        begin
            dark_ticks[i] = dark_ticks[i] + 8'd1;
            drive_led(i, 1'b0);
        end
        else
        begin
            // gap over: restart the burst, leave the LED undriven
            toggle_bits[i] = 1'b0;
            dark_ticks[i] = 8'd0;
            halves[i] = 2'd0;
        end
    endfunction

    function automatic tick_result_t step_led_patterns();
        tick_result_t res;
        driven_now = '0;
        for (int i = 0; i < mlbpc_pkg::MAX_SLOTS; i++)
        begin
            if (led_active[i] && i < LED_COUNT)
            begin
                case (led_mode[i])
                    mlbpc_pkg::CMD_ON:     drive_led(i, 1'b1);
                    mlbpc_pkg::CMD_SLOW:   void'(step_half_period(i, slow_len));
                    mlbpc_pkg::CMD_QUICK:  void'(step_half_period(i, quick_len));
                    mlbpc_pkg::CMD_SINGLE: step_burst(i, SINGLE_LAST_HALF);
                    mlbpc_pkg::CMD_DOUBLE: step_burst(i, DOUBLE_LAST_HALF);
                    default:               drive_led(i, 1'b0);
                endcase
            end
        end
        res.levels = lit;
        res.driven = driven_now;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t wanted;
        if (!rst_n)
        begin
            slow_len = mlbpc_pkg::SLOW_HALF_RST;
            quick_len = mlbpc_pkg::QUICK_HALF_RST;
            pulse_len = mlbpc_pkg::PULSE_HALF_RST;
            dark_len = mlbpc_pkg::PULSE_DARK_RST;
            led_active = '0;
            toggle_bits = '0;
            lit = '0;
            driven_now = '0;
            for (int i = 0; i < mlbpc_pkg::MAX_SLOTS; i++)
            begin
                led_mode[i] = '0;
                phase[i] = '0;
                halves[i] = '0;
                dark_ticks[i] = '0;
            end
            tick_results_q.delete();
            fail_count = 0;
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (tick_results_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual levels %h driven %h",
                             $time, led_levels, led_driven);
                end
                else
                begin
                    wanted = tick_results_q.pop_front();
                    if (led_levels !== wanted.levels)
                    begin
                        fail_count++;
                        $display("%0t: led_levels expected %h actual %h",
                                 $time, wanted.levels, led_levels);
                    end
                    if (led_driven !== wanted.driven)
                    begin
                        fail_count++;
                        $display("%0t: led_driven expected %h actual %h",
                                 $time, wanted.driven, led_driven);
                    end
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    mlbpc_pkg::CFG_SLOW_HALF:  slow_len = cfg_data;
                    mlbpc_pkg::CFG_QUICK_HALF: quick_len = cfg_data;
                    mlbpc_pkg::CFG_PULSE_HALF: pulse_len = cfg_data;
                    mlbpc_pkg::CFG_PULSE_DARK: dark_len = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (command == mlbpc_pkg::CMD_TICK)
                    tick_results_q.push_back(step_led_patterns());
                else if (command <= mlbpc_pkg::CMD_DOUBLE && led_index < LED_COUNT)
                begin
                    // set: new mode, counters cleared, level left alone
                    led_active[led_index] = 1'b1;
                    led_mode[led_index] = command;
                    phase[led_index] = '0;
                    halves[led_index] = '0;
                    dark_ticks[led_index] = '0;
                    toggle_bits[led_index] = 1'b0;
                end
            end
            errors <= fail_count;
            pending <= tick_results_q.size();
        end
    end

endmodule

FILE: bench/multi_led_blink_pattern_controller_tb.sv
// Top of the testbench: clock, reset, requests, register writes and stalls for
// the blink pattern controller; the verdict comes from mlbpc_tb_checker.
// Depends on mlbpc_pkg, the controller RTL and mlbpc_tb_checker.
module multi_led_blink_pattern_controller_tb;

    typedef logic [2:0]                      cmd_bits_t;
    typedef logic [mlbpc_pkg::IDX_W-1:0]     idx_bits_t;
    typedef logic [mlbpc_pkg::CFG_W-1:0]     cfg_bits_t;

    localparam int        LEDS           = 8;
    localparam cmd_bits_t CMD_UNUSED     = 3'd7;
    localparam int        SETTLE_CYCLES  = 2 * (LEDS + 2) + 4;
    localparam int        WATCHDOG_LIMIT = 5000;
    localparam int        IDX_MAX        = (1 << mlbpc_pkg::IDX_W) - 1;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [2:0]                      command = mlbpc_pkg::CMD_TICK;
    logic [mlbpc_pkg::IDX_W-1:0]     led_index = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [mlbpc_pkg::OUT_W-1:0]     led_levels;
    logic [mlbpc_pkg::OUT_W-1:0]     led_driven;
    logic                            cfg_write_en = 1'b0;
    logic [mlbpc_pkg::CFG_IDX_W-1:0] cfg_index = mlbpc_pkg::CFG_SLOW_HALF;
    logic [mlbpc_pkg::CFG_W-1:0]     cfg_data = '0;
    int                              errors;
    int                              pending;
    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              quiet_cycles = 0;

    multi_led_blink_pattern_controller #(.LED_COUNT(LEDS)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .led_index(led_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .led_levels(led_levels), .led_driven(led_driven),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mlbpc_tb_checker #(.LED_COUNT(LEDS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .led_index(led_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .led_levels(led_levels), .led_driven(led_driven),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Hold the request until a cycle with stall low; stall is settled by the falling edge.
    task automatic send_request(input cmd_bits_t cmd, input idx_bits_t idx);
        logic go;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        led_index <= idx;
        do
        begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end while (!go);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input mlbpc_pkg::cfg_idx_t idx, input cfg_bits_t value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Set requests give no result, so hold off past the block's latency first.
    task automatic program_registers(input cfg_bits_t s, input cfg_bits_t q,
                                     input cfg_bits_t p, input cfg_bits_t d);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(mlbpc_pkg::CFG_SLOW_HALF, s);
        write_register(mlbpc_pkg::CFG_QUICK_HALF, q);
        write_register(mlbpc_pkg::CFG_PULSE_HALF, p);
        write_register(mlbpc_pkg::CFG_PULSE_DARK, d);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int count;
        int sent;
        int roll;
        cfg_bits_t top;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 82;

        // every mode on at least one LED, short periods and no dark gap
        program_registers('0, '0, '0, '0);
        send_request(mlbpc_pkg::CMD_OFF, 3'd0);
        send_request(mlbpc_pkg::CMD_ON, 3'd1);
        send_request(mlbpc_pkg::CMD_SLOW, 3'd2);
        send_request(mlbpc_pkg::CMD_QUICK, 3'd3);
        send_request(mlbpc_pkg::CMD_SINGLE, 3'd4);
        send_request(mlbpc_pkg::CMD_DOUBLE, 3'd5);
        send_request(mlbpc_pkg::CMD_DOUBLE, 3'd6);
        send_request(mlbpc_pkg::CMD_SINGLE, 3'd7);
        send_request(CMD_UNUSED, 3'd7);
        for (int k = 0; k < 12; k++)
            send_request(mlbpc_pkg::CMD_TICK, (k % 2 == 0) ? 3'd7 : 3'd0);

        for (int blk = 0; blk < 7; blk++)
        begin
            if (blk == 2)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 29;
            end
            else if (blk == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (blk)
                0:
                begin
                    program_registers('0, '0, '0, '0);
                    count = 250;
                end
                1:
                begin
                    program_registers(cfg_bits_t'($urandom_range(0, 3)),
                                      cfg_bits_t'($urandom_range(0, 3)),
                                      cfg_bits_t'($urandom_range(0, 3)),
                                      cfg_bits_t'($urandom_range(0, 3)));
                    count = 300;
                end
                2:
                begin
                    program_registers(cfg_bits_t'($urandom_range(0, 7)),
                                      cfg_bits_t'($urandom_range(0, 7)),
                                      cfg_bits_t'($urandom_range(0, 7)),
                                      cfg_bits_t'($urandom_range(0, 7)));
                    count = 300;
                end
                3:
                begin
                    top = '1;
                    program_registers(top, top, top, top);
                    count = 100;
                end
                4:
                begin
                    // lowered from the maximum while counters are high
                    program_registers(cfg_bits_t'($urandom_range(0, 15)),
                                      cfg_bits_t'($urandom_range(0, 3)),
                                      cfg_bits_t'($urandom_range(0, 5)),
                                      cfg_bits_t'($urandom_range(0, 10)));
                    count = 300;
                end
                5:
                begin
                    program_registers(mlbpc_pkg::SLOW_HALF_RST, mlbpc_pkg::QUICK_HALF_RST,
                                      mlbpc_pkg::PULSE_HALF_RST, mlbpc_pkg::PULSE_DARK_RST);
                    count = 200;
                end
                default:
                begin
                    program_registers(cfg_bits_t'($urandom_range(0, 2)),
                                      cfg_bits_t'($urandom_range(0, 2)),
                                      cfg_bits_t'($urandom_range(0, 2)),
                                      cfg_bits_t'($urandom_range(0, 2)));
                    count = 300;
                end
            endcase
            sent = 0;
            while (sent < count)
            begin
                if (sent == 150)
                    wait_drained();
                roll = $urandom_range(0, 99);
                if (roll < 84)
                begin
                    send_request(mlbpc_pkg::CMD_TICK, idx_bits_t'($urandom_range(0, IDX_MAX)));
                    sent++;
                end
                else if (roll < 97)
                begin
                    send_request(cmd_bits_t'($urandom_range(mlbpc_pkg::CMD_OFF,
                                                            mlbpc_pkg::CMD_DOUBLE)),
                                 idx_bits_t'($urandom_range(0, IDX_MAX)));
                    sent++;
                end
                else
                    send_request(CMD_UNUSED, idx_bits_t'($urandom_range(0, IDX_MAX)));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
